>>> hw/rtl/hcrd_pkg.sv
// Package for the chunked HTTP response deframer.
// Holds the state and result types, codes, register map and byte constants.
// No dependencies.
package hcrd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SIZE    = 3'd1,
    PH_DATA    = 3'd2,
    PH_TRAILER = 3'd3,
    PH_CLOSED  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CONSUMED = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_HEADERS  = 3'd2,
    KIND_END      = 3'd3,
    KIND_ERROR    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_STATUS  = 3'd1,
    ERR_HEADER_LONG = 3'd2,
    ERR_BAD_HEX     = 3'd3,
    ERR_EMPTY_SIZE  = 3'd4,
    ERR_CHUNK_BIG   = 3'd5,
    ERR_LINE_LONG   = 3'd6,
    ERR_CLOSED      = 3'd7
  } err_t;

  localparam int ADDR_W = 4;
  localparam logic [ADDR_W-1:0] REG_HEADER_LIMIT = 4'h0;
  localparam logic [ADDR_W-1:0] REG_LINE_LIMIT   = 4'h4;
  localparam logic [ADDR_W-1:0] REG_CHUNK_LIMIT  = 4'h8;

  localparam logic [15:0] HEADER_LIMIT_RST = 16'd4096;
  localparam logic [9:0]  LINE_LIMIT_RST   = 10'd300;
  localparam logic [15:0] CHUNK_LIMIT_RST  = 16'd65535;

  localparam logic [7:0]  CH_CR   = 8'h0D;
  localparam logic [7:0]  CH_LF   = 8'h0A;
  localparam logic [7:0]  CH_SEMI = 8'h3B;
  localparam logic [31:0] HEADER_END = 32'h0D0A0D0A;
  localparam logic [16:0] PREFIX_LEN = 17'd12;
  localparam logic [16:0] SIZE_SAT   = 17'h10000;
  localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;

  typedef struct packed {
    logic cr;
    logic bad;
    logic semi;
    logic digit;
  } line_flags_t;

  typedef struct packed {
    phase_t      phase;
    logic [16:0] header_count;
    logic [31:0] tail_window;
    logic        prefix_match;
    logic [9:0]  line_count;
    logic [16:0] size_value;
    line_flags_t line_flags;
    logic [15:0] bytes_left;
    logic        trailer_seen;
  } state_t;

  typedef struct packed {
    logic [15:0] header_limit;
    logic [9:0]  size_line_limit;
    logic [15:0] chunk_limit;
  } limits_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic       last;
    err_t       err;
  } result_t;

  // "HTTP/1.1 200"
  function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h48;
      4'd1:    b = 8'h54;
      4'd2:    b = 8'h54;
      4'd3:    b = 8'h50;
      4'd4:    b = 8'h2F;
      4'd5:    b = 8'h31;
      4'd6:    b = 8'h2E;
      4'd7:    b = 8'h31;
      4'd8:    b = 8'h20;
      4'd9:    b = 8'h32;
      4'd10:   b = 8'h30;
      4'd11:   b = 8'h30;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/hcrd_step.sv
// Per-byte step of the deframer: next state and result from one byte.
// Purely combinational; uses hcrd_pkg.
module hcrd_step
  import hcrd_pkg::*;
(
  input  state_t     st,
  input  limits_t    lim,
  input  logic [7:0] c,
  output state_t     st_next,
  output result_t    res
);

  logic [16:0] hc_next;
  logic [31:0] tw_next;
  logic        pm_next;
  line_flags_t fl;
  logic [16:0] sv;
  logic [20:0] sv_wide;
  logic [4:0]  hv;

  always_comb begin
    st_next     = st;
    res.kind    = KIND_CONSUMED;
    res.payload = 8'd0;
    res.last    = 1'b0;
    res.err     = ERR_NONE;
    hc_next     = st.header_count;
    tw_next     = st.tail_window;
    pm_next     = st.prefix_match;
    fl          = st.line_flags;
    sv          = st.size_value;
    sv_wide     = 21'd0;
    hv          = 5'd0;

    case (st.phase)
      PH_HEADER: begin
        if (st.header_count < PREFIX_LEN && prefix_byte(st.header_count[3:0]) != c) begin
          pm_next = 1'b0;
        end
        if (st.header_count != COUNT_MAX) begin
          hc_next = st.header_count + 17'd1;
        end
        tw_next = {st.tail_window[23:0], c};
        st_next.header_count = hc_next;
        st_next.tail_window  = tw_next;
        st_next.prefix_match = pm_next;
        if (tw_next == HEADER_END) begin
          if (hc_next < PREFIX_LEN || !pm_next) begin
            st_next.phase = PH_CLOSED;
            res.kind      = KIND_ERROR;
            res.err       = ERR_BAD_STATUS;
          end else begin
            st_next.phase      = PH_SIZE;
            st_next.line_count = 10'd0;
            st_next.size_value = 17'd0;
            st_next.line_flags = '0;
            res.kind           = KIND_HEADERS;
          end
        end else if (hc_next > {1'b0, lim.header_limit}) begin
          st_next.phase = PH_CLOSED;
          res.kind      = KIND_ERROR;
          res.err       = ERR_HEADER_LONG;
        end
      end

      PH_SIZE: begin
        if (st.line_flags.cr && c == CH_LF) begin
          if (st.line_flags.bad) begin
            st_next.phase = PH_CLOSED;
            res.kind      = KIND_ERROR;
            res.err       = ERR_BAD_HEX;
          end else if (!st.line_flags.digit) begin
            st_next.phase = PH_CLOSED;
            res.kind      = KIND_ERROR;
            res.err       = ERR_EMPTY_SIZE;
          end else if (st.size_value == 17'd0) begin
            st_next.phase = PH_CLOSED;
            res.kind      = KIND_END;
          end else if (st.size_value > {1'b0, lim.chunk_limit}) begin
            st_next.phase = PH_CLOSED;
            res.kind      = KIND_ERROR;
            res.err       = ERR_CHUNK_BIG;
          end else begin
            st_next.bytes_left = st.size_value[15:0];
            st_next.phase      = PH_DATA;
          end
        end else if (st.line_count >= lim.size_line_limit) begin
          st_next.phase = PH_CLOSED;
          res.kind      = KIND_ERROR;
          res.err       = ERR_LINE_LONG;
        end else begin
          st_next.line_count = st.line_count + 10'd1;
          // unresolved CR is an ordinary line character
          if (fl.cr) begin
            fl.cr = 1'b0;
            if (!fl.semi) fl.bad = 1'b1;
          end
          if (c == CH_CR) begin
            fl.cr = 1'b1;
          end else if (!fl.semi) begin
            if (c == CH_SEMI) begin
              fl.semi = 1'b1;
            end else begin
              hv = hex_digit(c);
              if (!hv[4]) begin
                fl.bad = 1'b1;
              end else begin
                fl.digit = 1'b1;
                if (!sv[16]) begin
                  sv_wide = {sv, 4'b0000} + {17'd0, hv[3:0]};
                  sv = (sv_wide > {4'd0, SIZE_SAT}) ? SIZE_SAT : sv_wide[16:0];
                end
              end
            end
          end
          st_next.line_flags = fl;
          st_next.size_value = sv;
        end
      end

      PH_DATA: begin
        res.kind    = KIND_PAYLOAD;
        res.payload = c;
        if (st.bytes_left <= 16'd1) begin
          res.last             = 1'b1;
          st_next.bytes_left   = 16'd0;
          st_next.trailer_seen = 1'b0;
          st_next.phase        = PH_TRAILER;
        end else begin
          st_next.bytes_left = st.bytes_left - 16'd1;
        end
      end

      PH_TRAILER: begin
        if (st.trailer_seen) begin
          st_next.trailer_seen = 1'b0;
          st_next.line_count   = 10'd0;
          st_next.size_value   = 17'd0;
          st_next.line_flags   = '0;
          st_next.phase        = PH_SIZE;
        end else begin
          st_next.trailer_seen = 1'b1;
        end
      end

      default: begin
        st_next.phase = PH_CLOSED;
        res.kind      = KIND_ERROR;
        res.err       = ERR_CLOSED;
      end
    endcase
  end

endmodule

>>> hw/rtl/http_chunked_response_deframer.sv
// Top level of the chunked HTTP response deframer: input register, step
// logic, result register and APB limit registers. Uses hcrd_pkg, hcrd_step.
//
//   port group  direction  beat
//   in_*        in         one response byte (in_byte)
//   out_*       out        result_kind, payload_byte, chunk_last, error_code
//   APB         in/out     header_limit @0, size_line_limit @4, chunk_limit @8
//
// One byte per cycle sustained while out_stall is low. A byte goes through the
// input register, then the step logic, into the result register.
// Stream state changes only when a byte moves into the result register.
// out_stall with out_valid set holds the result register and, once the input
// register is full, raises in_stall in the same cycle. rst resets state and limits.
module http_chunked_response_deframer
  import hcrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        result_kind,
  output logic [7:0]        payload_byte,
  output logic              chunk_last,
  output logic [2:0]        error_code,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  limits_t    lim;
  state_t     st;
  state_t     st_next;
  result_t    res_next;
  result_t    res;
  logic       in_full;
  logic [7:0] in_data;
  logic       advance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.header_limit    <= HEADER_LIMIT_RST;
      lim.size_line_limit <= LINE_LIMIT_RST;
      lim.chunk_limit     <= CHUNK_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_HEADER_LIMIT: lim.header_limit    <= pwdata[15:0];
        REG_LINE_LIMIT:   lim.size_line_limit <= pwdata[9:0];
        REG_CHUNK_LIMIT:  lim.chunk_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_HEADER_LIMIT: prdata = {16'd0, lim.header_limit};
      REG_LINE_LIMIT:   prdata = {22'd0, lim.size_line_limit};
      REG_CHUNK_LIMIT:  prdata = {16'd0, lim.chunk_limit};
      default:          prdata = 32'd0;
    endcase
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  hcrd_step u_step (
    .st      (st),
    .lim     (lim),
    .c       (in_data),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      st.phase           <= PH_HEADER;
      st.header_count    <= 17'd0;
      st.tail_window     <= 32'd0;
      st.prefix_match    <= 1'b1;
      st.line_count      <= 10'd0;
      st.size_value      <= 17'd0;
      st.line_flags      <= '0;
      st.bytes_left      <= 16'd0;
      st.trailer_seen    <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
      if (in_full) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      res <= res_next;
    end
  end

  assign result_kind  = res.kind;
  assign payload_byte = res.payload;
  assign chunk_last   = res.last;
  assign error_code   = res.err;

endmodule

>>> test/http_chunked_response_deframer_tb.sv
// Self-checking bench for http_chunked_response_deframer: one response stream,
// header then chunks under changing limits, predicted byte by byte.
// Depends on hcrd_pkg and the deframer RTL only.
module http_chunked_response_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcrd_pkg::*;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        result_kind;
  logic [7:0]        payload_byte;
  logic              chunk_last;
  logic [2:0]        error_code;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  http_chunked_response_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .payload_byte(payload_byte),
    .chunk_last(chunk_last), .error_code(error_code),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    logic [7:0] b;
    bit         known;
    result_t    want;
  } row_t;

  // limit registers as last written
  logic [15:0] hdr_cap   = HEADER_LIMIT_RST;
  logic [9:0]  line_cap  = LINE_LIMIT_RST;
  logic [15:0] chunk_cap = CHUNK_LIMIT_RST;

  // stream state
  phase_t      rx_phase      = PH_HEADER;
  logic [16:0] hdr_seen      = '0;
  logic [31:0] hdr_tail      = '0;
  bit          hdr_status_ok = 1'b1;
  logic [9:0]  szl_len       = '0;
  logic [16:0] szl_value     = '0;
  line_flags_t szl_flags     = '0;
  logic [15:0] data_left     = '0;
  bit          trailer_half  = 1'b0;

  string      status_text = "HTTP/1.1 200";
  result_t    expected_results[$];
  logic [7:0] stim_q[$];
  row_t       dir_rows[$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         press_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  function automatic void clear_line();
    szl_len = '0;
    szl_value = '0;
    szl_flags = '0;
  endfunction

  function automatic void size_char(input logic [7:0] c);
    int d;
    int unsigned acc;
    if (szl_flags.semi) return;
    if (c == CH_SEMI) begin
      szl_flags.semi = 1'b1;
      return;
    end
    d = nibble(c);
    if (d < 0) begin
      szl_flags.bad = 1'b1;
      return;
    end
    szl_flags.digit = 1'b1;
    if (szl_value >= SIZE_SAT) return;
    acc = szl_value * 16 + d;
    if (acc > SIZE_SAT) acc = SIZE_SAT;
    szl_value = acc[16:0];
  endfunction

  function automatic result_t close_with(input err_t e);
    result_t r;
    rx_phase = PH_CLOSED;
    r = '{KIND_ERROR, 8'h00, 1'b0, e};
    return r;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] c);
    result_t r;
    r = '{KIND_CONSUMED, 8'h00, 1'b0, ERR_NONE};
    case (rx_phase)
      PH_HEADER: begin
        if (hdr_seen < PREFIX_LEN && status_text[int'(hdr_seen)] != c) hdr_status_ok = 1'b0;
        if (hdr_seen != COUNT_MAX) hdr_seen++;
        hdr_tail = {hdr_tail[23:0], c};
        if (hdr_tail == HEADER_END) begin
          if (hdr_seen < PREFIX_LEN || !hdr_status_ok) begin
            r = close_with(ERR_BAD_STATUS);
          end else begin
            rx_phase = PH_SIZE;
            clear_line();
            r.kind = KIND_HEADERS;
          end
        end else if (hdr_seen > hdr_cap) begin
          r = close_with(ERR_HEADER_LONG);
        end
      end
      PH_SIZE: begin
        if (szl_flags.cr && c == CH_LF) begin
          if (szl_flags.bad) r = close_with(ERR_BAD_HEX);
          else if (!szl_flags.digit) r = close_with(ERR_EMPTY_SIZE);
          else if (szl_value == 0) begin
            rx_phase = PH_CLOSED;
            r.kind = KIND_END;
          end else if (szl_value > chunk_cap) begin
            r = close_with(ERR_CHUNK_BIG);
          end else begin
            data_left = szl_value[15:0];
            rx_phase = PH_DATA;
          end
        end else if (szl_len >= line_cap) begin
          r = close_with(ERR_LINE_LONG);
        end else begin
          szl_len++;
          if (szl_flags.cr) begin
            szl_flags.cr = 1'b0;
            size_char(CH_CR);
          end
          if (c == CH_CR) szl_flags.cr = 1'b1;
          else size_char(c);
        end
      end
      PH_DATA: begin
        r.kind = KIND_PAYLOAD;
        r.payload = c;
        if (data_left <= 1) begin
          r.last = 1'b1;
          data_left = '0;
          trailer_half = 1'b0;
          rx_phase = PH_TRAILER;
        end else begin
          data_left--;
        end
      end
      PH_TRAILER: begin
        if (trailer_half) begin
          trailer_half = 1'b0;
          clear_line();
          rx_phase = PH_SIZE;
        end else begin
          trailer_half = 1'b1;
        end
      end
      default: r = close_with(ERR_CLOSED);
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit known, input kind_t k,
                                  input logic [7:0] p, input logic l);
    row_t row;
    row.b = b;
    row.known = known;
    row.want = '{k, p, l, ERR_NONE};
    dir_rows.push_back(row);
  endfunction

  // size line in hex with random case, leading zeros and extension, kept within line_cap
  function automatic void push_size_line(input int unsigned val);
    int unsigned nd, room, z, k;
    logic [7:0] d, prev;
    nd = 1;
    while (nd < 8 && (val >> (4 * nd)) != 0) nd++;
    room = line_cap - 1 - nd;
    z = $urandom_range(0, room > 3 ? 3 : room);
    room -= z;
    repeat (z) stim_q.push_back(8'h30);
    for (k = nd; k > 0; k--) begin
      d = 8'((val >> (4 * (k - 1))) & 4'hF);
      if (d < 10) stim_q.push_back(8'h30 + d);
      else if ($urandom_range(1)) stim_q.push_back(8'(8'h41 + d - 10));
      else stim_q.push_back(8'(8'h61 + d - 10));
    end
    if (room > 0 && $urandom_range(2) == 0) begin
      stim_q.push_back(CH_SEMI);
      room--;
      prev = CH_SEMI;
      repeat ($urandom_range(0, room > 6 ? 6 : room)) begin
        d = ($urandom_range(7) == 0) ? CH_CR : 8'($urandom_range(255));
        if (prev == CH_CR && d == CH_LF) d = 8'h78;
        stim_q.push_back(d);
        prev = d;
      end
    end
    stim_q.push_back(CH_CR);
    stim_q.push_back(CH_LF);
  endfunction

  function automatic void add_chunk();
    int unsigned cap, sz;
    cap = ($urandom_range(4) == 0) ? 200 : 8;
    if (line_cap < 4 && cap > 15) cap = 15;
    if (cap > chunk_cap) cap = chunk_cap;
    sz = $urandom_range(1, cap);
    push_size_line(sz);
    repeat (sz) stim_q.push_back(8'($urandom_range(255)));
    repeat (2) stim_q.push_back(8'($urandom_range(255)));
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit known, input result_t want);
    result_t guess;
    bit held;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    guess = deframe_byte(b);
    expected_results.push_back(known ? want : guess);
  endtask

  task automatic send_all();
    @(posedge clk);
    while (stim_q.size() != 0) send_byte(stim_q.pop_front(), 1'b0, '0);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [ADDR_W-1:0] a, input logic [31:0] v);
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== v) begin
      $display("%0t readback @%h: expected %h actual %h", $time, a, v, rd);
      mismatches++;
    end
    case (a)
      REG_HEADER_LIMIT: hdr_cap = v[15:0];
      REG_LINE_LIMIT:   line_cap = v[9:0];
      REG_CHUNK_LIMIT:  chunk_cap = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input int unsigned h, input int unsigned l, input int unsigned c);
    write_limit(REG_HEADER_LIMIT, h);
    write_limit(REG_LINE_LIMIT, l);
    write_limit(REG_CHUNK_LIMIT, c);
  endtask

  // receiver: random stall, plus one long hold-off while press_on is set
  initial begin : receiver
    int unsigned hold_left;
    bit press_used;
    hold_left = 0;
    press_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (press_on && !press_used) begin
        press_used = 1'b1;
        hold_left = 199;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(negedge clk) begin : check_beat
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected beat: expected none actual kind %0d", $time, result_kind);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result_kind !== want.kind) begin
          $display("%0t result_kind: expected %0d actual %0d", $time, want.kind, result_kind);
          mismatches++;
        end
        if (payload_byte !== want.payload) begin
          $display("%0t payload_byte: expected %h actual %h", $time, want.payload,
                   payload_byte);
          mismatches++;
        end
        if (chunk_last !== want.last) begin
          $display("%0t chunk_last: expected %0d actual %0d", $time, want.last, chunk_last);
          mismatches++;
        end
        if (error_code !== want.err) begin
          $display("%0t error_code: expected %0d actual %0d", $time, want.err, error_code);
          mismatches++;
        end
      end
    end
  end

  initial begin : main
    int seg, i, k;
    logic [7:0] c;
    string hdr_text, crlf2;
    hdr_text = "HTTP/1.1 200\r\n\r\n";
    crlf2 = "\r\n\r\n";
    send_idle_pct = 10;
    recv_idle_pct = 46;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    if ($urandom_range(7) == 0) begin
      // broken header: the rest of the run sees a closed block
      case ($urandom_range(2))
        0: begin
          k = $urandom_range(11);
          for (i = 0; i < k; i++) stim_q.push_back(status_text[i]);
          foreach (crlf2[j]) stim_q.push_back(crlf2[j]);
        end
        1: begin
          k = $urandom_range(11);
          for (i = 0; i < 12; i++) begin
            c = status_text[i];
            if (i == k) c = c ^ 8'($urandom_range(1, 255));
            stim_q.push_back(c);
          end
          foreach (crlf2[j]) stim_q.push_back(crlf2[j]);
        end
        default: begin
          write_limit(REG_HEADER_LIMIT, $urandom_range(12, 40));
          for (i = 0; i < 12; i++) stim_q.push_back(status_text[i]);
          while (stim_q.size() <= hdr_cap) stim_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
      endcase
      send_all();
    end else begin
      // header ending exactly at the cap is still accepted
      if ($urandom_range(1)) write_limit(REG_HEADER_LIMIT, hdr_text.len());
      for (i = 0; i < hdr_text.len(); i++) begin
        add_row(hdr_text[i], 1'b1, (i == hdr_text.len() - 1) ? KIND_HEADERS : KIND_CONSUMED,
                8'h00, 1'b0);
      end
      add_row(8'h32, 1'b0, KIND_CONSUMED, 8'h00, 1'b0);
      add_row(CH_SEMI, 1'b0, KIND_CONSUMED, 8'h00, 1'b0);
      add_row(CH_CR, 1'b0, KIND_CONSUMED, 8'h00, 1'b0);
      add_row(CH_LF, 1'b0, KIND_CONSUMED, 8'h00, 1'b0);
      add_row(8'h00, 1'b1, KIND_PAYLOAD, 8'h00, 1'b0);
      add_row(8'hFF, 1'b1, KIND_PAYLOAD, 8'hFF, 1'b1);
      add_row(CH_CR, 1'b0, KIND_CONSUMED, 8'h00, 1'b0);
      add_row(CH_LF, 1'b0, KIND_CONSUMED, 8'h00, 1'b0);
      @(posedge clk);
      foreach (dir_rows[j]) send_byte(dir_rows[j].b, dir_rows[j].known, dir_rows[j].want);
      in_valid <= 1'b0;
    end
    drain();

    for (seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 46 : 0;
      recv_idle_pct = (seg < 2) ? 46 : (seg < 4) ? 10 : 0;
      case (seg)
        0: set_limits(65535, 1023, 65535);
        1: set_limits(12, 2, 1);
        default: set_limits($urandom_range(12, 65535), $urandom_range(2, 1023),
                            $urandom_range(1, 65535));
      endcase
      while (stim_q.size() < 220) begin
        if (rx_phase == PH_CLOSED) stim_q.push_back(8'($urandom_range(255)));
        else add_chunk();
      end
      press_on = (seg == 4);
      send_all();
      drain();
      press_on = 1'b0;
    end

    if (rx_phase != PH_CLOSED) begin
      set_limits($urandom_range(12, 65535), $urandom_range(12, 40),
                 $urandom_range(1) ? 65535 : $urandom_range(1, 300));
      case ($urandom_range(4))
        0: push_size_line(0);
        1: begin
          if ($urandom_range(1)) begin
            // CR not followed by LF ahead of any extension
            stim_q.push_back(8'h31);
            stim_q.push_back(CH_CR);
            stim_q.push_back(8'h32);
          end else begin
            stim_q.push_back(8'h37);
            do c = 8'($urandom_range(255));
            while (nibble(c) >= 0 || c == CH_SEMI || c == CH_CR);
            stim_q.push_back(c);
          end
          stim_q.push_back(CH_CR);
          stim_q.push_back(CH_LF);
        end
        2: begin
          if ($urandom_range(1)) begin
            stim_q.push_back(CH_SEMI);
            stim_q.push_back(8'h78);
          end
          stim_q.push_back(CH_CR);
          stim_q.push_back(CH_LF);
        end
        3: begin
          if (chunk_cap == 16'hFFFF || $urandom_range(1)) begin
            repeat (9) stim_q.push_back(8'h46);
            stim_q.push_back(CH_CR);
            stim_q.push_back(CH_LF);
          end else begin
            push_size_line(chunk_cap + 1);
          end
        end
        default: repeat (line_cap + 1) stim_q.push_back(8'($urandom_range(8'h30, 8'h7A)));
      endcase
    end
    repeat (30) stim_q.push_back(8'($urandom_range(255)));
    send_all();
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
